FILE: rtl/tbwb_pkg.sv
// Shared types, constants and helpers for the terrain box world bounds block.
// No dependencies; every other file except tbwb_if imports this package.
package tbwb_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int WORD_BITS   = 32;
   localparam int COEF_BITS   = 32;
   localparam int OUT_BITS    = 32;
   localparam int COUNT_BITS  = 16;
   localparam int ROWS        = 3;
   localparam int COLS        = 4;
   localparam int ROW_BITS    = $clog2(ROWS);
   localparam int SUM_BITS    = ((WORD_BITS > COEF_BITS) ? WORD_BITS : COEF_BITS) + 3;
   localparam int PROD_BITS   = COEF_BITS + WORD_BITS;
   localparam int STEPS       = 2 + 4 * ROWS;
   localparam int STEP_BITS   = $clog2(STEPS + 1);
   localparam int QUEUE_DEPTH = 2;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [COEF_BITS-1:0] coef_type;
   typedef logic signed [SUM_BITS-1:0]  sum_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;
   typedef logic signed [OUT_BITS-1:0]  out_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_INVALID,
      CMD_OVERFLOW,
      CMD_BOX
   } cmd_kind_type;

   // One classified command, front to back
   typedef struct packed {
      cmd_kind_type            kind;
      logic [ROW_BITS-1:0]     row_index;
      coef_type                m0;
      coef_type                m1;
      coef_type                m2;
      coef_type                m3;
      logic [COUNT_BITS-1:0]   steps_x;
      logic [COUNT_BITS-1:0]   steps_z;
      coef_type                spacing;
      word_type                base;
      word_type                top;
   } cmd_type;

   // One result beat
   typedef struct packed {
      status_type status;
      logic       part;
      logic       last_item;
      out_type    ax;
      out_type    ay;
      out_type    az;
      out_type    bx;
      out_type    by;
      out_type    bz;
   } rsp_type;

   function automatic logic fits_sum(input sum_type v);
      word_type t;
      t = v[WORD_BITS-1:0];
      return SUM_BITS'(t) == v;
   endfunction

   function automatic logic fits_prod(input prod_type v);
      word_type t;
      t = v[WORD_BITS-1:0];
      return PROD_BITS'(t) == v;
   endfunction

   function automatic out_type to_out(input word_type v);
      return OUT_BITS'(v);
   endfunction

endpackage

FILE: rtl/tbwb_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on nothing; payload fields are plain vectors.
interface tbwb_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [1:0]  row_index;
   logic [31:0] row_m0;
   logic [31:0] row_m1;
   logic [31:0] row_m2;
   logic [31:0] row_m3;
   logic [15:0] count_x;
   logic [15:0] count_z;
   logic [31:0] spacing;
   logic [31:0] base_height;
   logic [31:0] height_span;
   logic        snapshot_failed;

   modport source (output valid, mode, row_index, row_m0, row_m1, row_m2, row_m3,
                   count_x, count_z, spacing, base_height, height_span, snapshot_failed,
                   input ready);
   modport sink (input valid, mode, row_index, row_m0, row_m1, row_m2, row_m3,
                 count_x, count_z, spacing, base_height, height_span, snapshot_failed,
                 output ready);
endinterface

interface tbwb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        part;
   logic        last_item;
   logic [31:0] ax;
   logic [31:0] ay;
   logic [31:0] az;
   logic [31:0] bx;
   logic [31:0] by;
   logic [31:0] bz;

   modport source (output valid, status, part, last_item, ax, ay, az, bx, by, bz,
                   input ready);
   modport sink (input valid, status, part, last_item, ax, ay, az, bx, by, bz,
                 output ready);
endinterface

FILE: rtl/tbwb_front.sv
// Front end: classifies a request beat into a load, a rejected layout, an out-of-range layout or a box job.
// Depends on tbwb_pkg.
module tbwb_front (
   input  logic                    mode,
   input  logic [1:0]              row_index,
   input  logic [31:0]             row_m0,
   input  logic [31:0]             row_m1,
   input  logic [31:0]             row_m2,
   input  logic [31:0]             row_m3,
   input  logic [15:0]             count_x,
   input  logic [15:0]             count_z,
   input  logic [31:0]             spacing,
   input  logic [31:0]             base_height,
   input  logic [31:0]             height_span,
   input  logic                    snapshot_failed,
   output tbwb_pkg::cmd_type       cmd,
   output logic                    keep
);
   import tbwb_pkg::*;

   sum_type base_s;
   sum_type top_s;
   logic    bad_layout;
   logic    bad_range;

   // Validate layout and form the local top
   always_comb begin
      base_s     = SUM_BITS'($signed(base_height));
      top_s      = base_s + SUM_BITS'($signed(height_span));
      bad_layout = snapshot_failed || (count_x < 16'd2) || (count_z < 16'd2) ||
                   ($signed(spacing) <= 0) || ($signed(height_span) <= 0);
      bad_range  = !fits_sum(top_s) || !fits_sum(base_s);
   end

   // Build the command
   always_comb begin
      cmd.row_index = row_index[ROW_BITS-1:0];
      cmd.m0        = $signed(row_m0);
      cmd.m1        = $signed(row_m1);
      cmd.m2        = $signed(row_m2);
      cmd.m3        = $signed(row_m3);
      cmd.steps_x   = count_x - 16'd1;
      cmd.steps_z   = count_z - 16'd1;
      cmd.spacing   = $signed(spacing);
      cmd.base      = base_s[WORD_BITS-1:0];
      cmd.top       = top_s[WORD_BITS-1:0];
      keep          = 1'b1;
      if (!mode) begin
         cmd.kind = CMD_LOAD;
         keep     = (row_index < 2'(ROWS));
      end else if (bad_layout) begin
         cmd.kind = CMD_INVALID;
      end else if (bad_range) begin
         cmd.kind = CMD_OVERFLOW;
      end else begin
         cmd.kind = CMD_BOX;
      end
   end

endmodule

FILE: rtl/tbwb_queue.sv
// Short command queue between front and back ends.
// Depends on tbwb_pkg.
module tbwb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tbwb_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output tbwb_pkg::cmd_type pop_cmd
);
   import tbwb_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;

   assign full      = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CNT_BITS'(push) - CNT_BITS'(pop);
      end
   end

endmodule

FILE: rtl/tbwb_back.sv
// Back end: matrix store, shared multiplier sequence and result register.
// Depends on tbwb_pkg.
module tbwb_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  tbwb_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tbwb_pkg::rsp_type rsp
);
   import tbwb_pkg::*;

   typedef enum logic [1:0] {IDLE, CALC, PART0, PART1} state_type;

   state_type            state_ff;
   coef_type             matrix_ff [ROWS][COLS];
   cmd_type              cur_ff;
   logic [STEP_BITS-1:0] cnt_ff;
   prod_type             prod_ff;
   logic                 ovf_ff;
   word_type             hi_x_ff;
   word_type             hi_z_ff;
   word_type             ya_ff;
   coef_type             trans_ff;
   sum_type              rmin_ff;
   sum_type              rmax_ff;
   word_type             wmin_ff [ROWS];
   word_type             wmax_ff [ROWS];
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic                 slot_free;
   logic [STEP_BITS-1:0] issue_m;
   logic [ROW_BITS-1:0]  issue_row;
   logic [1:0]           issue_j;
   coef_type             op_a;
   word_type             op_b;
   logic [STEP_BITS-1:0] proc_q;
   logic [STEP_BITS-1:0] proc_m;
   logic [ROW_BITS-1:0]  proc_row;
   logic [1:0]           proc_j;
   prod_type             shifted;
   word_type             pw;
   logic                 p_ovf;
   word_type             pair_a;
   word_type             lo_t;
   word_type             hi_t;
   sum_type              sum_lo;
   sum_type              sum_hi;
   sum_type              c_sum [ROWS];
   sum_type              c_dif [ROWS];
   logic                 rsp_load;
   rsp_type              rsp_in;
   logic                 rsp_valid_in;

   function automatic logic cur_kind_ok(input cmd_kind_type k);
      return (k == CMD_LOAD) || (k == CMD_BOX);
   endfunction

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign cmd_pop   = (state_ff == IDLE) && cmd_valid &&
                      ((cur_kind_ok(cmd.kind)) || slot_free);

   // Select multiplier operands for the step being issued
   always_comb begin
      issue_m   = cnt_ff - STEP_BITS'(2);
      issue_row = ROW_BITS'(issue_m >> 2);
      issue_j   = issue_m[1:0];
      op_a      = cur_ff.spacing;
      op_b      = WORD_BITS'(cur_ff.steps_x);
      if (cnt_ff == STEP_BITS'(1)) begin
         op_b = WORD_BITS'(cur_ff.steps_z);
      end else if (cnt_ff >= STEP_BITS'(2) && cnt_ff < STEP_BITS'(STEPS)) begin
         unique case (issue_j)
            2'd0: begin
               op_a = matrix_ff[issue_row][0];
               op_b = hi_x_ff;
            end
            2'd1: begin
               op_a = matrix_ff[issue_row][1];
               op_b = cur_ff.base;
            end
            2'd2: begin
               op_a = matrix_ff[issue_row][1];
               op_b = cur_ff.top;
            end
            default: begin
               op_a = matrix_ff[issue_row][2];
               op_b = hi_z_ff;
            end
         endcase
      end
   end

   // Scale and bound the registered product, then fold it into the row range
   always_comb begin
      proc_q   = cnt_ff - STEP_BITS'(1);
      proc_m   = cnt_ff - STEP_BITS'(3);
      proc_row = ROW_BITS'(proc_m >> 2);
      proc_j   = proc_m[1:0];
      shifted  = (proc_q < STEP_BITS'(2)) ? prod_ff : (prod_ff >>> FRAC_BITS);
      p_ovf    = !fits_prod(shifted);
      pw       = shifted[WORD_BITS-1:0];
      pair_a   = (proc_j == 2'd2) ? ya_ff : '0;
      lo_t     = (pw < pair_a) ? pw : pair_a;
      hi_t     = (pw > pair_a) ? pw : pair_a;
      sum_lo   = ((proc_j == 2'd0) ? SUM_BITS'(trans_ff) : rmin_ff) + SUM_BITS'(lo_t);
      sum_hi   = ((proc_j == 2'd0) ? SUM_BITS'(trans_ff) : rmax_ff) + SUM_BITS'(hi_t);
   end

   // Center and half extents
   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         c_sum[r] = (SUM_BITS'(wmin_ff[r]) + SUM_BITS'(wmax_ff[r])) >>> 1;
         c_dif[r] = (SUM_BITS'(wmax_ff[r]) - SUM_BITS'(wmin_ff[r])) >>> 1;
      end
   end

   // Form the next result beat
   always_comb begin
      rsp_load = 1'b0;
      rsp_in   = '0;
      unique case (state_ff)
         IDLE: begin
            if (cmd_pop && !cur_kind_ok(cmd.kind)) begin
               rsp_load         = 1'b1;
               rsp_in.last_item = 1'b1;
               if (cmd.kind == CMD_INVALID) begin
                  rsp_in.status = STATUS_INVALID;
               end else begin
                  rsp_in.status = STATUS_OVERFLOW;
               end
            end
         end
         CALC: begin
         end
         PART0: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               if (ovf_ff) begin
                  rsp_in.status    = STATUS_OVERFLOW;
                  rsp_in.last_item = 1'b1;
               end else begin
                  rsp_in.status = STATUS_OK;
                  rsp_in.ax     = to_out(wmin_ff[0]);
                  rsp_in.ay     = to_out(wmin_ff[1]);
                  rsp_in.az     = to_out(wmin_ff[2]);
                  rsp_in.bx     = to_out(wmax_ff[0]);
                  rsp_in.by     = to_out(wmax_ff[1]);
                  rsp_in.bz     = to_out(wmax_ff[2]);
               end
            end
         end
         default: begin
            if (slot_free) begin
               rsp_load         = 1'b1;
               rsp_in.status    = STATUS_OK;
               rsp_in.part      = 1'b1;
               rsp_in.last_item = 1'b1;
               rsp_in.ax        = to_out(c_sum[0][WORD_BITS-1:0]);
               rsp_in.ay        = to_out(c_sum[1][WORD_BITS-1:0]);
               rsp_in.az        = to_out(c_sum[2][WORD_BITS-1:0]);
               rsp_in.bx        = to_out(c_dif[0][WORD_BITS-1:0]);
               rsp_in.by        = to_out(c_dif[1][WORD_BITS-1:0]);
               rsp_in.bz        = to_out(c_dif[2][WORD_BITS-1:0]);
            end
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   // Sequencer, matrix store and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < ROWS; r++) begin
            for (int k = 0; k < COLS; k++) begin
               matrix_ff[r][k] <= '0;
            end
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (rsp_load) begin
            rsp_ff <= rsp_in;
         end
         unique case (state_ff)
            IDLE: begin
               if (cmd_pop) begin
                  unique case (cmd.kind)
                     CMD_LOAD: begin
                        matrix_ff[cmd.row_index][0] <= cmd.m0;
                        matrix_ff[cmd.row_index][1] <= cmd.m1;
                        matrix_ff[cmd.row_index][2] <= cmd.m2;
                        matrix_ff[cmd.row_index][3] <= cmd.m3;
                     end
                     CMD_BOX: begin
                        cur_ff   <= cmd;
                        cnt_ff   <= '0;
                        ovf_ff   <= 1'b0;
                        state_ff <= CALC;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            CALC: begin
               prod_ff <= op_a * op_b;
               cnt_ff  <= cnt_ff + 1'b1;
               if (cnt_ff >= STEP_BITS'(2) && cnt_ff < STEP_BITS'(STEPS) &&
                   issue_j == 2'd0) begin
                  trans_ff <= matrix_ff[issue_row][3];
               end
               if (cnt_ff != '0) begin
                  if (p_ovf) begin
                     ovf_ff <= 1'b1;
                  end
                  if (proc_q == '0) begin
                     hi_x_ff <= pw;
                  end else if (proc_q == STEP_BITS'(1)) begin
                     hi_z_ff <= pw;
                  end else begin
                     unique case (proc_j)
                        2'd1: ya_ff <= pw;
                        2'd3: begin
                           wmin_ff[proc_row] <= sum_lo[WORD_BITS-1:0];
                           wmax_ff[proc_row] <= sum_hi[WORD_BITS-1:0];
                           if (!fits_sum(sum_lo) || !fits_sum(sum_hi)) begin
                              ovf_ff <= 1'b1;
                           end
                        end
                        default: begin
                           rmin_ff <= sum_lo;
                           rmax_ff <= sum_hi;
                        end
                     endcase
                  end
               end
               if (cnt_ff == STEP_BITS'(STEPS)) begin
                  state_ff <= PART0;
               end
            end
            PART0: begin
               if (slot_free) begin
                  state_ff <= ovf_ff ? IDLE : PART1;
               end
            end
            default: begin
               if (slot_free) begin
                  state_ff <= IDLE;
               end
            end
         endcase
      end
   end

endmodule

FILE: rtl/terrain_box_world_bounds.sv
// Top level of the terrain box world bounds block.
// Depends on tbwb_pkg, tbwb_if, tbwb_front, tbwb_queue and tbwb_back.
//
// Usage:
//   req_if carries one beat per item. Mode 0 loads one row (0..2) of the 3x4
//   world matrix and gives no response; row 3 is dropped. Mode 1 carries a
//   height-grid layout and gives one response beat (status invalid or overflow)
//   or two (min/max, then center/extents, the second with last_item set).
//   Requests pass a classifier into a two-entry queue; req_if.ready is low only
//   while the queue is full.
// Sequencing:
//   A row load is written into the matrix when the back end pops it. A box job
//   runs 14 products through one shared multiplier, one per cycle, then gives
//   its response beats; the back end takes no new command until the last of
//   them is loaded into the result register.
//   A rejected layout's response is loaded into the result register as the back end pops it.
// Reset clears the matrix to zero, empties the queue and drops any response.
// A stalled response holds in its output register; the back end waits before loading another
// beat, and the queue keeps taking requests until it is full.
module terrain_box_world_bounds (
   input  logic        clock,
   input  logic        reset,
   tbwb_req_if.sink    req_if,
   tbwb_rsp_if.source  rsp_if
);
   import tbwb_pkg::*;

   cmd_type front_cmd;
   logic    front_keep;
   cmd_type queue_cmd;
   logic    queue_full;
   logic    queue_not_empty;
   logic    queue_pop;
   logic    rsp_valid;
   rsp_type rsp;

   assign req_if.ready = !queue_full;

   tbwb_front u_front (
      .mode            (req_if.mode),
      .row_index       (req_if.row_index),
      .row_m0          (req_if.row_m0),
      .row_m1          (req_if.row_m1),
      .row_m2          (req_if.row_m2),
      .row_m3          (req_if.row_m3),
      .count_x         (req_if.count_x),
      .count_z         (req_if.count_z),
      .spacing         (req_if.spacing),
      .base_height     (req_if.base_height),
      .height_span     (req_if.height_span),
      .snapshot_failed (req_if.snapshot_failed),
      .cmd             (front_cmd),
      .keep            (front_keep)
   );

   tbwb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_if.valid && !queue_full && front_keep),
      .push_cmd  (front_cmd),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_cmd   (queue_cmd)
   );

   tbwb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_not_empty),
      .cmd       (queue_cmd),
      .cmd_pop   (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .rsp       (rsp)
   );

   // Drive the response channel
   assign rsp_if.valid     = rsp_valid;
   assign rsp_if.status    = rsp.status;
   assign rsp_if.part      = rsp.part;
   assign rsp_if.last_item = rsp.last_item;
   assign rsp_if.ax        = rsp.ax;
   assign rsp_if.ay        = rsp.ay;
   assign rsp_if.az        = rsp.az;
   assign rsp_if.bx        = rsp.bx;
   assign rsp_if.by        = rsp.by;
   assign rsp_if.bz        = rsp.bz;

endmodule

FILE: rtl/tbwb_checker.sv
// Port-level checks on the response channel of terrain_box_world_bounds.
// Depends on tbwb_pkg; attached to the top level by the bind below.
module tbwb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  status,
   input logic        part,
   input logic        last_item,
   input logic [31:0] ax,
   input logic [31:0] bx
);
   import tbwb_pkg::*;

   // Stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(part) &&
      $stable(ax))
      else $error("response changed while stalled");

   // Second part is always the ok, final beat
   a_part1: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && part |-> last_item && status == STATUS_OK)
      else $error("center/extents beat malformed");

   // Error beats are single, zeroed and final
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != STATUS_OK |-> last_item && !part && ax == '0 && bx == '0)
      else $error("error beat malformed");

   // A non-final beat is only an ok min/max beat
   a_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !last_item |-> !part && status == STATUS_OK)
      else $error("non-final beat malformed");

endmodule

bind terrain_box_world_bounds tbwb_checker u_tbwb_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .status    (rsp_if.status),
   .part      (rsp_if.part),
   .last_item (rsp_if.last_item),
   .ax        (rsp_if.ax),
   .bx        (rsp_if.bx)
);
